FILE: src/lpcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpcc_pkg
// Shared types, status bit masks and reset values of the carriage controller.
// ----------------------------------------------------------------------------
package lpcc_pkg;

   localparam int ROW_W     = 7;
   localparam int CHAN_W    = 8;
   localparam int WHEEL_W   = 6;
   localparam int STATUS_W  = 16;
   localparam int MOD_W     = 16;
   localparam int ACTION_W  = 3;
   localparam int ERR_W     = 2;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 8;

   localparam int WHEEL_POSITIONS_DEF = 48;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 40;

   localparam logic [STATUS_W-1:0] ST_EMITTER   = 16'h8000;
   localparam logic [STATUS_W-1:0] ST_SKIP_RSP  = 16'h4000;
   localparam logic [STATUS_W-1:0] ST_SPACE_RSP = 16'h2000;
   localparam logic [STATUS_W-1:0] ST_CARR_BUSY = 16'h1000;
   localparam logic [STATUS_W-1:0] ST_NOT_READY = 16'h0400;
   localparam logic [STATUS_W-1:0] ST_PRT_BUSY  = 16'h0200;
   localparam logic [STATUS_W-1:0] ST_CHANNELS  = 16'h00FF;

   localparam logic [MOD_W-1:0] MOD_RESET_RSP   = 16'h0001;
   localparam logic [MOD_W-1:0] MOD_START_PRINT = 16'h0080;
   localparam logic [MOD_W-1:0] MOD_STOP_PRINT  = 16'h0040;
   localparam logic [MOD_W-1:0] MOD_START_SKIP  = 16'h0004;
   localparam logic [MOD_W-1:0] MOD_STOP_SKIP   = 16'h0002;
   localparam logic [MOD_W-1:0] MOD_SPACE       = 16'h0001;

   typedef enum logic [ACTION_W-1:0] {
      ACT_READ    = 3'd0,
      ACT_SENSE   = 3'd1,
      ACT_CONTROL = 3'd2,
      ACT_TICK    = 3'd3
   } action_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_NONE       = 2'd0,
      ERR_BAD_ACTION = 2'd1,
      ERR_SKIP_SPACE = 2'd2
   } err_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PAGE_LENGTH = 3'd0,
      CSR_PUNCH_A_ROW = 3'd1,
      CSR_PUNCH_A_CH  = 3'd2,
      CSR_PUNCH_B_ROW = 3'd3,
      CSR_PUNCH_B_CH  = 3'd4,
      CSR_ONLINE      = 3'd5
   } csr_idx_type;

   localparam logic [ROW_W-1:0]  PAGE_LENGTH_RST = 7'd66;
   localparam logic [ROW_W-1:0]  PUNCH_A_ROW_RST = 7'd6;
   localparam logic [CHAN_W-1:0] PUNCH_A_CH_RST  = 8'd1;
   localparam logic [ROW_W-1:0]  PUNCH_B_ROW_RST = 7'd12;
   localparam logic [CHAN_W-1:0] PUNCH_B_CH_RST  = 8'd128;
   localparam logic              ONLINE_RST      = 1'b1;

   function automatic logic [CHAN_W-1:0] row_channels(
      input logic [ROW_W-1:0]  row,
      input logic [ROW_W-1:0]  a_row,
      input logic [CHAN_W-1:0] a_ch,
      input logic [ROW_W-1:0]  b_row,
      input logic [CHAN_W-1:0] b_ch
   );
      logic [CHAN_W-1:0] c;
      c = '0;
      if (row == a_row) c = c | a_ch;
      if (row == b_row) c = c | b_ch;
      return c;
   endfunction

   localparam logic [STATUS_W-1:0] STATUS_RST =
      {8'h00, row_channels(7'd0, PUNCH_A_ROW_RST, PUNCH_A_CH_RST,
                           PUNCH_B_ROW_RST, PUNCH_B_CH_RST)}
      | (ONLINE_RST ? 16'h0000 : ST_NOT_READY);

endpackage

FILE: src/line_printer_carriage_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_printer_carriage_controller
// Drum line printer controller: read, sense, control and service tick words.
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  req     | in  | tuser: action; tdata: modifier, buffer_ready
//  rsp     | out | tdata: read_data, status_word, interrupt_request,
//          |     |        forms_check_lamp, print_check_lamp, error_code,
//          |     |        current_row
//  csr     | in  | write enable, register index, write data
//
//  One word per cycle while results are taken; the result is registered and shows in the cycle after acceptance.
//  Next punched row of a skip is found by comparing both punches in one pass.
//  Synchronous active-high reset restores registers and clears all activity.
//  A stalled result holds in the output register; req_tready drops only then.
// ----------------------------------------------------------------------------
module line_printer_carriage_controller
   import lpcc_pkg::*;
#(
   parameter int WHEEL_POSITIONS = WHEEL_POSITIONS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [REQ_DATA_W-1:0]   req_tdata,  // modifier[15:0], buffer_ready[16]
   input  logic [ACTION_W-1:0]     req_tuser,  // action[2:0]
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // read_data[5:0], status_word[21:6], interrupt_request[22],
   // forms_check_lamp[23], print_check_lamp[24], error_code[26:25],
   // current_row[33:27]
   output logic [RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   logic [ROW_W-1:0]    page_length_ff, punch_a_row_ff, punch_b_row_ff;
   logic [CHAN_W-1:0]   punch_a_ch_ff, punch_b_ch_ff;
   logic                online_ff;

   logic [STATUS_W-1:0] status_ff, status_in, status_cfg_in;
   logic                print_ff, print_in, skip_ff, skip_in, space_ff, space_in;
   logic [WHEEL_W-1:0]  wheel_ff, wheel_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic                pend_ff, pend_in, irq_ff, irq_in;
   logic                forms_ff, forms_in, dchk_ff, dchk_in;

   logic                rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                accept;
   action_type          action;
   logic [MOD_W-1:0]    modifier;
   logic                buf_ready;
   logic [WHEEL_W-1:0]  rd;
   logic [STATUS_W-1:0] sw;
   err_type             err;
   logic [ROW_W-1:0]    row_sp, row_sk;
   logic [WHEEL_W-1:0]  wheel_adv;

   function automatic logic [ROW_W-1:0] adv_row(
      input logic [ROW_W-1:0] r,
      input logic [ROW_W-1:0] len
   );
      logic [ROW_W:0] n;
      n = {1'b0, r} + 8'd1;
      return (n >= {1'b0, len}) ? '0 : n[ROW_W-1:0];
   endfunction

   // row where a skip from r stops
   function automatic logic [ROW_W-1:0] skip_row(
      input logic [ROW_W-1:0] r,
      input logic [ROW_W-1:0] len,
      input logic [ROW_W-1:0] qa,
      input logic             ca,
      input logic [ROW_W-1:0] qb,
      input logic             cb
   );
      logic           in_page, va, vb;
      logic [ROW_W:0] da, db;
      logic [ROW_W-1:0] res;
      in_page = r < len;
      va = ca && (qa < len);
      vb = cb && (qb < len);
      if (in_page) begin
         da = (qa > r) ? ({1'b0, qa} - {1'b0, r}) : ({1'b0, qa} + {1'b0, len} - {1'b0, r});
         db = (qb > r) ? ({1'b0, qb} - {1'b0, r}) : ({1'b0, qb} + {1'b0, len} - {1'b0, r});
      end else begin
         da = {1'b0, qa} + 8'd1;
         db = {1'b0, qb} + 8'd1;
      end
      if (len == '0) begin
         res = '0;
      end else if (va && (!vb || da <= db)) begin
         res = qa;
      end else if (vb) begin
         res = qb;
      end else begin
         res = in_page ? r : len - 7'd1;
      end
      return res;
   endfunction

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign action    = action_type'(req_tuser);
   assign modifier  = req_tdata[MOD_W-1:0];
   assign buf_ready = req_tdata[MOD_W];

   always_comb begin
      logic [WHEEL_W:0] wn;
      wn = {1'b0, wheel_ff} + 7'd1;
      wheel_adv = (wn >= (WHEEL_W+1)'(WHEEL_POSITIONS)) ? '0 : wn[WHEEL_W-1:0];
   end

   assign row_sp = space_ff ? adv_row(row_ff, page_length_ff) : row_ff;
   assign row_sk = skip_row(row_sp, page_length_ff, punch_a_row_ff, |punch_a_ch_ff,
                            punch_b_row_ff, |punch_b_ch_ff);

   always_comb begin
      status_in = status_ff;
      print_in  = print_ff;
      skip_in   = skip_ff;
      space_in  = space_ff;
      wheel_in  = wheel_ff;
      row_in    = row_ff;
      pend_in   = pend_ff;
      irq_in    = irq_ff;
      forms_in  = forms_ff;
      dchk_in   = dchk_ff;
      rd        = '0;
      sw        = '0;
      err       = ERR_NONE;
      case (action)
         ACT_READ: begin
            rd = wheel_ff;
            if (!print_ff) wheel_in = wheel_adv;
         end
         ACT_SENSE: begin
            sw = status_ff;
            if ((modifier & MOD_RESET_RSP) != '0) begin
               status_in = status_ff & ~(ST_EMITTER | ST_SKIP_RSP | ST_SPACE_RSP);
               irq_in    = 1'b0;
            end
         end
         ACT_CONTROL: begin
            if ((modifier & MOD_START_PRINT) != '0) print_in = 1'b1;
            if ((modifier & MOD_STOP_PRINT)  != '0) print_in = 1'b0;
            if ((modifier & MOD_START_SKIP)  != '0) skip_in  = 1'b1;
            if ((modifier & MOD_STOP_SKIP)   != '0) skip_in  = 1'b0;
            if ((modifier & MOD_SPACE)       != '0) space_in = 1'b1;
            pend_in   = print_in || skip_in || space_in;
            status_in = pend_in ? (status_in | ST_PRT_BUSY) : (status_in & ~ST_PRT_BUSY);
            status_in = (skip_in || space_in) ? (status_in | ST_CARR_BUSY)
                                              : (status_in & ~ST_CARR_BUSY);
            if (skip_in && space_in) err = ERR_SKIP_SPACE;
         end
         ACT_TICK: begin
            if (pend_ff) begin
               pend_in = 1'b0;
               if ((status_ff & ST_NOT_READY) != '0) begin
                  forms_in = 1'b1;
                  print_in = 1'b0;
                  skip_in  = 1'b0;
                  space_in = 1'b0;
               end else begin
                  if (space_ff) begin
                     row_in    = row_sp;
                     status_in = (status_in & ~(ST_PRT_BUSY | ST_CARR_BUSY))
                                 | ST_SPACE_RSP;
                     irq_in    = 1'b1;
                     space_in  = 1'b0;
                  end
                  if (skip_ff) begin
                     row_in    = row_sk;
                     status_in = status_in | ST_SKIP_RSP;
                     irq_in    = 1'b1;
                  end
                  // channel bits follow the row only when the carriage moves
                  if (space_ff || skip_ff) begin
                     status_in = (status_in & ~ST_CHANNELS)
                                 | {8'h00, row_channels(row_in, punch_a_row_ff,
                                    punch_a_ch_ff, punch_b_row_ff, punch_b_ch_ff)};
                  end
                  if (print_ff && !buf_ready) begin
                     dchk_in  = 1'b1;
                     print_in = 1'b0;
                     skip_in  = 1'b0;
                     space_in = 1'b0;
                  end else begin
                     if (print_ff) begin
                        wheel_in  = wheel_adv;
                        status_in = status_in | ST_EMITTER;
                        irq_in    = 1'b1;
                     end
                     if (print_ff || skip_ff) begin
                        status_in = status_in | ST_PRT_BUSY;
                        pend_in   = 1'b1;
                     end else begin
                        status_in = status_in & ~ST_PRT_BUSY;
                     end
                  end
               end
            end
         end
         default: begin
            err = ERR_BAD_ACTION;
         end
      endcase
      rsp_data_in = {6'd0, row_in, err, dchk_in, forms_in, irq_in, sw, rd};
   end

   // not-ready bit follows the online register write
   always_comb begin
      status_cfg_in = accept ? status_in : status_ff;
      if (csr_we && (csr_idx_type'(csr_index) == CSR_ONLINE)) begin
         status_cfg_in = csr_wdata[0] ? (status_cfg_in & ~ST_NOT_READY)
                                      : (status_cfg_in | ST_NOT_READY);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_length_ff <= PAGE_LENGTH_RST;
         punch_a_row_ff <= PUNCH_A_ROW_RST;
         punch_a_ch_ff  <= PUNCH_A_CH_RST;
         punch_b_row_ff <= PUNCH_B_ROW_RST;
         punch_b_ch_ff  <= PUNCH_B_CH_RST;
         online_ff      <= ONLINE_RST;
         status_ff      <= STATUS_RST;
         print_ff       <= 1'b0;
         skip_ff        <= 1'b0;
         space_ff       <= 1'b0;
         wheel_ff       <= '0;
         row_ff         <= '0;
         pend_ff        <= 1'b0;
         irq_ff         <= 1'b0;
         forms_ff       <= 1'b0;
         dchk_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         status_ff <= status_cfg_in;
         if (accept) begin
            print_ff     <= print_in;
            skip_ff      <= skip_in;
            space_ff     <= space_in;
            wheel_ff     <= wheel_in;
            row_ff       <= row_in;
            pend_ff      <= pend_in;
            irq_ff       <= irq_in;
            forms_ff     <= forms_in;
            dchk_ff      <= dchk_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            case (csr_idx_type'(csr_index))
               CSR_PAGE_LENGTH: page_length_ff <= csr_wdata[ROW_W-1:0];
               CSR_PUNCH_A_ROW: punch_a_row_ff <= csr_wdata[ROW_W-1:0];
               CSR_PUNCH_A_CH:  punch_a_ch_ff  <= csr_wdata;
               CSR_PUNCH_B_ROW: punch_b_row_ff <= csr_wdata[ROW_W-1:0];
               CSR_PUNCH_B_CH:  punch_b_ch_ff  <= csr_wdata;
               CSR_ONLINE:      online_ff      <= csr_wdata[0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) rsp_data_ff <= rsp_data_in;
   end

   // a pending event always has an activity behind it
   a_pend_tracks_activity: assert property (@(posedge clock) disable iff (reset)
      pend_ff == (print_ff || skip_ff || space_ff))
      else $error("event pending out of step with activities");

   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      row_ff != 7'h7F)
      else $error("page row out of range");

   a_wheel_in_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, wheel_ff} < 7'(WHEEL_POSITIONS))
      else $error("wheel position out of range");

   a_online_matches_status: assert property (@(posedge clock) disable iff (reset)
      online_ff == ((status_ff & ST_NOT_READY) == '0))
      else $error("not-ready bit disagrees with online register");

   a_err_code_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff[26:25] != 2'd3)
      else $error("undefined error code");

endmodule

FILE: tb/line_printer_carriage_controller_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_printer_carriage_controller_tb
// Self-checking bench for the printer carriage controller. A short table of
// read, sense, control, tick and undefined action words runs first, then random
// command streams under six carriage settings, with random idling on both stream
// sides and one long result stall. Each result word is compared field by field
// with a fixed table reply or with the bench's behavioral controller copy.
// ----------------------------------------------------------------------------
module line_printer_carriage_controller_tb;
   import lpcc_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_WORDS   = 88;
   localparam int STALL_AT_WORD  = 60;
   localparam int STALL_CYCLES   = 120;

   // rsp_tdata layout, lowest bits last
   typedef struct packed {
      logic [5:0]          pad;
      logic [ROW_W-1:0]    row;
      logic [ERR_W-1:0]    err;
      logic                print_chk;
      logic                forms_chk;
      logic                irq;
      logic [STATUS_W-1:0] status;
      logic [WHEEL_W-1:0]  rd;
   } reply_word_type;

   typedef struct packed {
      logic [ACTION_W-1:0] act;
      logic [MOD_W-1:0]    modf;
      logic                rdy;
      logic                fixed;
      reply_word_type      want;
   } drill_row_type;

   localparam reply_word_type REPLY_QUIET = '0;
   localparam reply_word_type REPLY_BAD_ACTION =
      {6'd0, 7'd0, ERR_BAD_ACTION, 3'b000, 16'h0000, 6'd0};
   localparam reply_word_type REPLY_SKIP_SPACE =
      {6'd0, 7'd0, ERR_SKIP_SPACE, 3'b000, 16'h0000, 6'd0};

   localparam int DRILL_N = 25;
   localparam drill_row_type DRILL [DRILL_N] = '{
      '{ACT_SENSE,   16'h0000, 1'b1, 1'b1, REPLY_QUIET},
      '{ACT_READ,    16'h0000, 1'b0, 1'b1, REPLY_QUIET},
      '{3'd4,        16'hFFFF, 1'b1, 1'b1, REPLY_BAD_ACTION},
      '{3'd7,        16'h0000, 1'b0, 1'b1, REPLY_BAD_ACTION},
      '{ACT_TICK,    16'h0000, 1'b1, 1'b0, REPLY_QUIET},   // nothing pending
      '{ACT_CONTROL, 16'h0005, 1'b1, 1'b1, REPLY_SKIP_SPACE},
      '{ACT_TICK,    16'hFFFF, 1'b1, 1'b0, REPLY_QUIET},
      '{ACT_SENSE,   16'h0001, 1'b0, 1'b0, REPLY_QUIET},
      '{ACT_CONTROL, 16'h0002, 1'b1, 1'b0, REPLY_QUIET},
      '{ACT_CONTROL, 16'h0080, 1'b1, 1'b0, REPLY_QUIET},
      '{ACT_TICK,    16'h0000, 1'b1, 1'b0, REPLY_QUIET},
      '{ACT_READ,    16'h0000, 1'b1, 1'b0, REPLY_QUIET},   // printing: wheel holds
      '{ACT_TICK,    16'h0000, 1'b0, 1'b0, REPLY_QUIET},   // hammer buffer late
      '{ACT_SENSE,   16'h0001, 1'b1, 1'b0, REPLY_QUIET},
      '{ACT_CONTROL, 16'h00C0, 1'b1, 1'b0, REPLY_QUIET},   // stop beats start
      '{ACT_CONTROL, 16'h0001, 1'b1, 1'b0, REPLY_QUIET},
      '{ACT_TICK,    16'h0000, 1'b1, 1'b0, REPLY_QUIET},
      '{ACT_CONTROL, 16'h0004, 1'b0, 1'b0, REPLY_QUIET},
      '{ACT_TICK,    16'h0000, 1'b1, 1'b0, REPLY_QUIET},
      '{ACT_TICK,    16'h0000, 1'b1, 1'b0, REPLY_QUIET},
      '{ACT_CONTROL, 16'hFFFF, 1'b1, 1'b0, REPLY_QUIET},
      '{ACT_TICK,    16'h0000, 1'b1, 1'b0, REPLY_QUIET},
      '{ACT_SENSE,   16'hFFFE, 1'b1, 1'b0, REPLY_QUIET},
      '{ACT_CONTROL, 16'h0042, 1'b1, 1'b0, REPLY_QUIET},
      '{3'd5,        16'h8000, 1'b1, 1'b0, REPLY_QUIET}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;  // modifier[15:0], buffer_ready[16]
   logic [ACTION_W-1:0]   req_tuser = '0;  // action[2:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // read_data[5:0], status_word[21:6], interrupt_request[22],
   // forms_check_lamp[23], print_check_lamp[24], error_code[26:25],
   // current_row[33:27]
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // typed expectation travelling with the word on the bus
   logic                  drv_fixed = 1'b0;
   reply_word_type        drv_want = '0;

   // carriage copy
   logic [ROW_W-1:0]    cfg_page_len, cfg_a_row, cfg_b_row;
   logic [CHAN_W-1:0]   cfg_a_ch, cfg_b_ch;
   logic                cfg_online;
   logic [STATUS_W-1:0] m_status;
   logic                m_print, m_skip, m_space, m_pending;
   logic                m_irq, m_forms, m_dchk;
   logic [WHEEL_W-1:0]  m_wheel;
   logic [ROW_W-1:0]    m_row;

   reply_word_type carriage_replies[$];
   int fails = 0;
   int words_in = 0;
   int ticks_in = 0;
   int replies_checked = 0;
   int settings_used = 1;
   int idle_cycles = 0;
   bit tx_burst = 1'b0;

   line_printer_carriage_controller u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   function automatic logic [CHAN_W-1:0] punch_bits(input logic [ROW_W-1:0] row);
      logic [CHAN_W-1:0] c;
      c = '0;
      if (row == cfg_a_row) c |= cfg_a_ch;
      if (row == cfg_b_row) c |= cfg_b_ch;
      return c;
   endfunction

   task automatic carriage_reset();
      cfg_page_len = PAGE_LENGTH_RST;
      cfg_a_row    = PUNCH_A_ROW_RST;
      cfg_a_ch     = PUNCH_A_CH_RST;
      cfg_b_row    = PUNCH_B_ROW_RST;
      cfg_b_ch     = PUNCH_B_CH_RST;
      cfg_online   = ONLINE_RST;
      {m_print, m_skip, m_space, m_pending, m_irq, m_forms, m_dchk} = '0;
      m_wheel  = '0;
      m_row    = '0;
      m_status = {8'h00, punch_bits('0)};
      if (!cfg_online) m_status |= ST_NOT_READY;
   endtask

   task automatic row_next();
      int n;
      n = int'(m_row) + 1;
      m_row = (n >= int'(cfg_page_len)) ? '0 : ROW_W'(n);
      m_status[CHAN_W-1:0] = punch_bits(m_row);
   endtask

   task automatic wheel_next();
      int n;
      n = int'(m_wheel) + 1;
      m_wheel = (n >= WHEEL_POSITIONS_DEF) ? '0 : WHEEL_W'(n);
   endtask

   task automatic stop_motion();
      m_print = 1'b0;
      m_skip  = 1'b0;
      m_space = 1'b0;
   endtask

   task automatic service_tick(input logic rdy);
      int steps;
      if (!m_pending) return;
      m_pending = 1'b0;
      if ((m_status & ST_NOT_READY) != 0) begin
         m_forms = 1'b1;
         stop_motion();
         return;
      end
      if (m_space) begin
         row_next();
         m_status |= ST_SPACE_RSP;
         m_irq = 1'b1;
         m_space = 1'b0;
         m_status &= ~(ST_PRT_BUSY | ST_CARR_BUSY);
      end
      if (m_skip) begin
         steps = 0;
         do begin
            row_next();
            steps++;
         end while (m_status[CHAN_W-1:0] == 0 && steps < int'(cfg_page_len));
         m_status |= ST_SKIP_RSP;
         m_irq = 1'b1;
      end
      if (m_print) begin
         if (!rdy) begin
            m_dchk = 1'b1;
            stop_motion();
            return;
         end
         wheel_next();
         m_status |= ST_EMITTER;
         m_irq = 1'b1;
      end
      if (m_print || m_skip || m_space) begin
         m_status |= ST_PRT_BUSY;
         m_pending = 1'b1;
      end else begin
         m_status &= ~ST_PRT_BUSY;
      end
   endtask

   task automatic carriage_step(input logic [ACTION_W-1:0] act, input logic [MOD_W-1:0] modf,
                                input logic rdy, output reply_word_type r);
      r = '0;
      case (act)
         ACT_READ: begin
            r.rd = m_wheel;
            if (!m_print) wheel_next();
         end
         ACT_SENSE: begin
            r.status = m_status;
            if ((modf & MOD_RESET_RSP) != 0) begin
               m_status &= ~(ST_EMITTER | ST_SKIP_RSP | ST_SPACE_RSP);
               m_irq = 1'b0;
            end
         end
         ACT_CONTROL: begin
            if ((modf & MOD_START_PRINT) != 0) m_print = 1'b1;
            if ((modf & MOD_STOP_PRINT) != 0)  m_print = 1'b0;
            if ((modf & MOD_START_SKIP) != 0)  m_skip  = 1'b1;
            if ((modf & MOD_STOP_SKIP) != 0)   m_skip  = 1'b0;
            if ((modf & MOD_SPACE) != 0)       m_space = 1'b1;
            if (m_print || m_skip || m_space) begin
               m_status |= ST_PRT_BUSY;
               m_pending = 1'b1;
            end else begin
               m_status &= ~ST_PRT_BUSY;
               m_pending = 1'b0;
            end
            if (m_skip || m_space) m_status |= ST_CARR_BUSY;
            else m_status &= ~ST_CARR_BUSY;
            if (m_skip && m_space) r.err = ERR_SKIP_SPACE;
         end
         ACT_TICK: service_tick(rdy);
         default: r.err = ERR_BAD_ACTION;
      endcase
      r.irq       = m_irq;
      r.forms_chk = m_forms;
      r.print_chk = m_dchk;
      r.row       = m_row;
   endtask

   // prediction on acceptance, comparison on result, register mirror
   always @(posedge clock) begin
      reply_word_type want, got;
      if (reset) begin
         carriage_reset();
         carriage_replies.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            carriage_step(req_tuser, req_tdata[MOD_W-1:0], req_tdata[MOD_W], want);
            carriage_replies.push_back(drv_fixed ? drv_want : want);
            words_in++;
            if (req_tuser == ACT_TICK) ticks_in++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = reply_word_type'(rsp_tdata);
            if (carriage_replies.size() == 0) begin
               $error("result word with nothing expected: %h", rsp_tdata);
               fails++;
            end else begin
               want = carriage_replies.pop_front();
               replies_checked++;
               if (got.rd !== want.rd) begin
                  $error("read_data: expected %0d, got %0d", want.rd, got.rd);
                  fails++;
               end
               if (got.status !== want.status) begin
                  $error("status_word: expected %h, got %h", want.status, got.status);
                  fails++;
               end
               if (got.irq !== want.irq) begin
                  $error("interrupt_request: expected %b, got %b", want.irq, got.irq);
                  fails++;
               end
               if (got.forms_chk !== want.forms_chk) begin
                  $error("forms_check_lamp: expected %b, got %b",
                         want.forms_chk, got.forms_chk);
                  fails++;
               end
               if (got.print_chk !== want.print_chk) begin
                  $error("print_check_lamp: expected %b, got %b",
                         want.print_chk, got.print_chk);
                  fails++;
               end
               if (got.err !== want.err) begin
                  $error("error_code: expected %0d, got %0d", want.err, got.err);
                  fails++;
               end
               if (got.row !== want.row) begin
                  $error("current_row: expected %0d, got %0d", want.row, got.row);
                  fails++;
               end
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_PAGE_LENGTH: cfg_page_len = csr_wdata[ROW_W-1:0];
               CSR_PUNCH_A_ROW: cfg_a_row    = csr_wdata[ROW_W-1:0];
               CSR_PUNCH_A_CH:  cfg_a_ch     = csr_wdata;
               CSR_PUNCH_B_ROW: cfg_b_row    = csr_wdata[ROW_W-1:0];
               CSR_PUNCH_B_CH:  cfg_b_ch     = csr_wdata;
               CSR_ONLINE: begin
                  cfg_online = csr_wdata[0];
                  if (cfg_online) m_status &= ~ST_NOT_READY;
                  else m_status |= ST_NOT_READY;
               end
               default: ;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no traffic for %0d cycles, %0d results outstanding",
                     idle_cycles, carriage_replies.size());
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // result side: random stalls, one long hold-off
   initial begin : reply_sink
      int taken;
      int gap;
      bit burst;
      taken = 0;
      burst = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         if ($urandom_range(0, 24) == 0) burst = !burst;
         gap = burst ? 0 : $urandom_range(0, 16);
         if (taken == STALL_AT_WORD) gap = STALL_CYCLES;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         taken++;
         @(negedge clock);
      end
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic offer(input logic [ACTION_W-1:0] act, input logic [MOD_W-1:0] modf,
                        input logic rdy, input logic fixed, input reply_word_type want);
      int gap;
      if ($urandom_range(0, 24) == 0) tx_burst = !tx_burst;
      gap = tx_burst ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {7'd0, rdy, modf};
      drv_fixed  <= fixed;
      drv_want   <= want;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic random_words(input int count);
      int pick;
      logic [ACTION_W-1:0] act;
      logic [MOD_W-1:0] modf;
      logic [7:0] cmd;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         modf = MOD_W'($urandom);
         if (pick < 8) act = ACTION_W'($urandom_range(4, 7));
         else if (pick < 22) act = ACT_READ;
         else if (pick < 37) act = ACT_SENSE;
         else if (pick < 62) act = ACT_CONTROL;
         else act = ACT_TICK;
         if (act == ACT_CONTROL && $urandom_range(0, 4) != 0) begin
            cmd = modf[7:0] & 8'h38;
            if ($urandom_range(0, 9) < 4) cmd |= MOD_START_PRINT[7:0];
            if ($urandom_range(0, 9) < 2) cmd |= MOD_STOP_PRINT[7:0];
            if ($urandom_range(0, 9) < 3) cmd |= MOD_START_SKIP[7:0];
            if ($urandom_range(0, 9) < 3) cmd |= MOD_STOP_SKIP[7:0];
            if ($urandom_range(0, 9) < 4) cmd |= MOD_SPACE[7:0];
            modf[7:0] = cmd;
         end
         offer(act, modf, $urandom_range(0, 9) != 0, 1'b0, REPLY_QUIET);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (carriage_replies.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_reg(input csr_idx_type idx, input logic [CSR_DATA_W-1:0] d);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      @(negedge clock);
   endtask

   task automatic set_carriage(input int len, input int a_row, input int a_ch,
                               input int b_row, input int b_ch, input int online);
      drain();
      write_reg(CSR_PAGE_LENGTH, CSR_DATA_W'(len));
      write_reg(CSR_PUNCH_A_ROW, CSR_DATA_W'(a_row));
      write_reg(CSR_PUNCH_A_CH,  CSR_DATA_W'(a_ch));
      write_reg(CSR_PUNCH_B_ROW, CSR_DATA_W'(b_row));
      write_reg(CSR_PUNCH_B_CH,  CSR_DATA_W'(b_ch));
      write_reg(CSR_ONLINE,      CSR_DATA_W'(online));
      csr_we <= 1'b0;
      settings_used++;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < DRILL_N; i++)
         offer(DRILL[i].act, DRILL[i].modf, DRILL[i].rdy, DRILL[i].fixed, DRILL[i].want);
      random_words(RANDOM_WORDS);

      // longest form, punch at the last row, empty second punch
      set_carriage(127, 126, 255, 0, 0, 1);
      random_words(RANDOM_WORDS);
      // one-row form with no punches
      set_carriage(1, 0, 0, 0, 0, 1);
      random_words(RANDOM_WORDS);
      // printer offline
      set_carriage(20, 126, 8'h55, 3, 8'h80, 0);
      random_words(RANDOM_WORDS);
      // short form, both punches on one row
      set_carriage(5, 2, 8'h01, 2, 8'h02, 1);
      random_words(RANDOM_WORDS);
      set_carriage($urandom_range(1, 127), $urandom_range(0, 126), $urandom_range(0, 255),
                   $urandom_range(0, 126), $urandom_range(0, 255), 1);
      random_words(RANDOM_WORDS);

      drain();
      repeat (8) @(negedge clock);
      $display("covered %0d words (%0d service ticks) over %0d carriage settings",
               words_in, ticks_in, settings_used);
      $display("%0d result words checked, %0d mismatches", replies_checked, fails);
      if (fails == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

FILE: filelist.f
src/lpcc_pkg.sv
src/line_printer_carriage_controller.sv
tb/line_printer_carriage_controller_tb.sv
